// ===== rtl/core/prcw_pkg.sv =====
`default_nettype none
package prcw_pkg;

  // Divider geometry: numerator up to 42 bits, divisor up to 11 bits
  localparam int unsigned NumW     = 42;
  localparam int unsigned DenW     = 11;
  localparam int unsigned DivSteps = NumW;

  // Field layout of the control word
  localparam int unsigned MfnLsb = 0;
  localparam int unsigned MfiLsb = 10;
  localparam int unsigned MfdLsb = 16;
  localparam int unsigned PdLsb  = 26;

  localparam logic [3:0] MfiFloor = 4'd5;

  // Chip variant codes
  localparam logic [1:0] VarUnsigned = 2'd0;
  localparam logic [1:0] VarSignMag  = 2'd1;
  localparam logic [1:0] VarTwosComp = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgRefRate = 2'd0;
  localparam logic [1:0] CfgVariant = 2'd1;

  // Decode stage, both dividers, scale stage and the output register
  localparam int unsigned Latency = 1 + DivSteps + 1 + DivSteps + 1;

  // Sideband that rides along with an item through the pipeline
  typedef struct packed {
    logic [3:0]  mfi;
    logic [9:0]  mag;
    logic        neg;
    logic [9:0]  mfd;
    logic [35:0] whole;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/prcw_div.sv =====
`default_nettype none
module prcw_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [prcw_pkg::NumW-1:0]     numer_i,
  input  wire logic [prcw_pkg::DenW-1:0]     denom_i,
  input  wire prcw_pkg::side_t               side_i,
  output logic                               valid_o,
  output logic [prcw_pkg::NumW-1:0]          quot_o,
  output prcw_pkg::side_t                    side_o
);

  localparam int unsigned N = prcw_pkg::DivSteps;
  localparam int unsigned W = prcw_pkg::NumW;
  localparam int unsigned D = prcw_pkg::DenW;

  // Stage s holds the partial remainder and the numerator/quotient shifter
  logic [W-1:0]    num_q  [N];
  logic [D-1:0]    rem_q  [N];
  logic [D-1:0]    den_q  [N];
  prcw_pkg::side_t side_q [N];
  logic            vld_q  [N];

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [W-1:0]    num_in;
    logic [D-1:0]    rem_in;
    logic [D-1:0]    den_in;
    prcw_pkg::side_t side_in;
    logic            vld_in;
    logic [D:0]      trial;
    logic            ge;
    logic [D-1:0]    rem_d;

    // Take the first step from the ports, the rest from the previous stage
    if (s == 0) begin : g_head
      assign num_in  = numer_i;
      assign rem_in  = '0;
      assign den_in  = denom_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_tail
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // Shift in one numerator bit and subtract when it fits
    always_comb begin
      trial = {rem_in, num_in[W-1]};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? D'(trial - {1'b0, den_in}) : trial[D-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s]  <= {num_in[W-2:0], ge};
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = num_q[N-1];
  assign side_o  = side_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/prcw_scale.sv =====
`default_nettype none
module prcw_scale (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire logic [31:0]               base_i,
  input  wire prcw_pkg::side_t           side_i,
  output logic                           valid_o,
  output logic [prcw_pkg::NumW-1:0]      frac_num_o,
  output prcw_pkg::side_t                side_o
);

  logic                         valid_q;
  logic [prcw_pkg::NumW-1:0]    frac_q;
  prcw_pkg::side_t              side_d;
  prcw_pkg::side_t              side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Attach base*mfi to the sideband
  always_comb begin
    side_d       = side_i;
    side_d.whole = {4'd0, base_i} * {32'd0, side_i.mfi};
  end

  // Form base*mag and base*mfi side by side
  always_ff @(posedge clk_i) begin
    frac_q <= {10'd0, base_i} * {32'd0, side_i.mag};
    side_q <= side_d;
  end

  assign valid_o    = valid_q;
  assign frac_num_o = frac_q;
  assign side_o     = side_q;

endmodule
`default_nettype wire

// ===== rtl/core/pll_rate_from_control_word.sv =====
`default_nettype none
// PLL output rate from a control word.
// Write reference_rate (index 0) and chip_variant (index 1) on the cfg
// channel while idle; cfg_ready_o is always high. Issue a control word by
// raising start_i; busy_o stays low, so a new word may enter every cycle.
// Each word produces one beat on output_rate_o, marked by valid_o for one
// cycle, after one decode stage, a 42-step divider by pd+1, one multiply
// stage, a 42-step divider by mfd+1 and one output stage. Throughput is
// one word per cycle.
// Results leave in issue order. The receiver cannot stall; each beat is
// presented once and is gone the cycle after.
// Reset clears all valid bits in the pipeline, sets reference_rate to 0
// and chip_variant to two's complement; items in flight are dropped.
module pll_rate_from_control_word (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [31:0]        control_word_i,
  output logic                    valid_o,
  output logic signed [43:0]      output_rate_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic [30:0] ref_rate_q;
  logic [1:0]  variant_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_rate_q <= '0;
      variant_q  <= prcw_pkg::VarTwosComp;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == prcw_pkg::CfgRefRate) begin
        ref_rate_q <= cfg_data_i[30:0];
      end else if (cfg_index_i == prcw_pkg::CfgVariant) begin
        variant_q <= cfg_data_i[1:0];
      end
    end
  end

  // Decode stage: unpack fields, clamp mfi to its floor and resolve mfn sign
  logic [9:0]      mfn;
  logic [3:0]      mfi_raw;
  logic [3:0]      pd;
  prcw_pkg::side_t dec_d;
  prcw_pkg::side_t dec_q;
  logic [3:0]      pd_q;
  logic            dec_vld_q;

  always_comb begin
    mfn       = control_word_i[prcw_pkg::MfnLsb +: 10];
    mfi_raw   = control_word_i[prcw_pkg::MfiLsb +: 4];
    pd        = control_word_i[prcw_pkg::PdLsb +: 4];
    dec_d     = '0;
    dec_d.mfd = control_word_i[prcw_pkg::MfdLsb +: 10];
    dec_d.mfi = (mfi_raw < prcw_pkg::MfiFloor) ? prcw_pkg::MfiFloor : mfi_raw;
    dec_d.mag = mfn;
    if (variant_q != prcw_pkg::VarUnsigned && mfn[9]) begin
      dec_d.neg = 1'b1;
      if (variant_q == prcw_pkg::VarSignMag) begin
        dec_d.mag = {1'b0, mfn[8:0]};
      end else begin
        dec_d.mag = 10'(11'h400 - {1'b0, mfn});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_vld_q <= 1'b0;
    end else begin
      dec_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    pd_q  <= pd;
  end

  // Divide 2*fref by pd+1
  logic                        div1_vld;
  logic [prcw_pkg::NumW-1:0]   div1_quot;
  prcw_pkg::side_t             div1_side;

  prcw_div u_div_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_vld_q),
    .numer_i ({10'd0, ref_rate_q, 1'b0}),
    .denom_i ({6'd0, {1'b0, pd_q} + 5'd1}),
    .side_i  (dec_q),
    .valid_o (div1_vld),
    .quot_o  (div1_quot),
    .side_o  (div1_side)
  );

  // Multiply base by mag and by mfi
  logic                        scl_vld;
  logic [prcw_pkg::NumW-1:0]   scl_frac;
  prcw_pkg::side_t             scl_side;

  prcw_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (div1_vld),
    .base_i     (div1_quot[31:0]),
    .side_i     (div1_side),
    .valid_o    (scl_vld),
    .frac_num_o (scl_frac),
    .side_o     (scl_side)
  );

  // Divide base*mag by mfd+1
  logic                        div2_vld;
  logic [prcw_pkg::NumW-1:0]   div2_quot;
  prcw_pkg::side_t             div2_side;

  prcw_div u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scl_vld),
    .numer_i (scl_frac),
    .denom_i ({1'b0, scl_side.mfd} + 11'd1),
    .side_i  (scl_side),
    .valid_o (div2_vld),
    .quot_o  (div2_quot),
    .side_o  (div2_side)
  );

  // Combine whole and fractional terms
  logic        out_vld_q;
  logic [43:0] rate_q;
  logic [43:0] whole_ext;
  logic [43:0] frac_ext;

  assign whole_ext = {8'd0, div2_side.whole};
  assign frac_ext  = {2'd0, div2_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= div2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= div2_side.neg ? (whole_ext - frac_ext) : (whole_ext + frac_ext);
  end

  assign valid_o       = out_vld_q;
  assign output_rate_o = signed'(rate_q);

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, prcw_pkg::Latency))
    else $error("result beat without a matching start");
  a_base_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div1_vld |-> (div1_quot[prcw_pkg::NumW-1:32] == '0))
    else $error("base quotient exceeds 32 bits");
  a_mfi_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div2_vld |-> (div2_side.mfi >= prcw_pkg::MfiFloor))
    else $error("mfi below floor in flight");
`endif

endmodule
`default_nettype wire
